>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared wrappers for concurrent assertions in checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every edge outside reset
`define RSBR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define RSBR_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/rsbr_pkg.sv
// ----------------------------------------------------------------------------
// rsbr_pkg
// shared types and constants of the raster sampler and screen point blender
// ----------------------------------------------------------------------------
package rsbr_pkg;

  // raster and fixed point geometry
  localparam int COORD_BITS = 12;
  localparam int SIZE_W     = COORD_BITS + 1;
  localparam int ROW_W      = 13;
  localparam int WT_W       = 16;
  localparam int STEP_W     = WT_W + 1;
  localparam int REM_W      = SIZE_W;
  localparam int HALF_SHIFT = WT_W - 1;
  localparam int DIV_NUM_W  = REM_W + WT_W;
  localparam int DIV_STEPS  = WT_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int POINT_W    = 16;
  localparam int NUM_AXES   = 3;

  // configuration port
  localparam int CFG_DATA_W = 48;
  localparam int CFG_IDX_W  = 3;

  localparam int QUEUE_DEPTH_DEF = 4;

  typedef logic [COORD_BITS-1:0]  coord_t;
  typedef logic [SIZE_W-1:0]      size_t;
  typedef logic [ROW_W-1:0]       row_t;
  typedef logic [WT_W-1:0]        wt_t;
  typedef logic [STEP_W-1:0]      step_t;
  typedef logic [REM_W-1:0]       rem_t;
  typedef logic signed [POINT_W-1:0] point_t;
  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

  localparam size_t SIZE_MAX    = SIZE_W'(1 << COORD_BITS);
  localparam size_t SIZE_ONE    = SIZE_W'(1);
  localparam size_t WIDE_RESET  = SIZE_W'(640);
  localparam size_t HIGH_RESET  = SIZE_W'(480);

  // register indexes
  localparam cfg_idx_t REG_PIXELS_WIDE  = CFG_IDX_W'(0);
  localparam cfg_idx_t REG_PIXELS_HIGH  = CFG_IDX_W'(1);
  localparam cfg_idx_t REG_EYE_POSITION = CFG_IDX_W'(2);
  localparam cfg_idx_t REG_CORNER_LL    = CFG_IDX_W'(3);
  localparam cfg_idx_t REG_CORNER_UL    = CFG_IDX_W'(4);
  localparam cfg_idx_t REG_CORNER_LR    = CFG_IDX_W'(5);
  localparam cfg_idx_t REG_CORNER_UR    = CFG_IDX_W'(6);

  // weight position along one axis: quotient and remainder against the size
  typedef struct packed {
    wt_t  q;
    rem_t r;
  } wpos_t;

  // per-pixel increment of a weight position
  typedef struct packed {
    step_t q;
    rem_t  r;
  } wstep_t;

  // divider request and response
  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    size_t                den;
  } div_req_t;

  typedef struct packed {
    logic done;
    wt_t  quo;
    rem_t rem;
  } div_rsp_t;

  // classified request handed from front to back
  typedef struct packed {
    coord_t sx;
    coord_t sy;
    wt_t    u;
    wt_t    v;
    logic   done;
  } item_t;

endpackage

>>> rtl/rsbr_if.sv
// ----------------------------------------------------------------------------
// rsbr channel interfaces
// valid/ready channels for the restart request and the sample result
// ----------------------------------------------------------------------------
interface rsbr_in_if;
  import rsbr_pkg::*;

  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface rsbr_out_if;
  import rsbr_pkg::*;

  logic   valid;
  logic   ready;
  coord_t sample_x;
  coord_t sample_y;
  point_t point_x;
  point_t point_y;
  point_t point_z;
  logic   done_res;

  modport source (output valid, output sample_x, output sample_y, output point_x,
                  output point_y, output point_z, output done_res, input ready);
  modport sink   (input valid, input sample_x, input sample_y, input point_x,
                  input point_y, input point_z, input done_res, output ready);
endinterface

>>> rtl/raster_sample_bilinear_raygen.sv
// ----------------------------------------------------------------------------
// raster_sample_bilinear_raygen
// raster scan sampler giving pixel centres and their points on a screen quad
// ----------------------------------------------------------------------------
//  channel  direction  request carries
//  in_ch    sink       restart
//  out_ch   source     sample_x, sample_y, point_x/y/z, done_res
//  cfg_*    sink       register write: index, data (no handshake)
//
//  one request per cycle sustained; the front keeps incremental weights so
//  the scan needs no divide per pixel, and the blend pipeline is 4 stages
//  deep: a taken request is written to the queue, then passes stages s1,
//  s2, s3 and the output register before its result shows on out_ch.
//  after reset and after each width or height write the front runs its
//  weight setup on the shared divider (4 jobs) with in_ch.ready low. a
//  stalled out_ch fills the 4-entry queue, then in_ch.ready drops. the eye
//  position has no part in the result and is not stored.
// ----------------------------------------------------------------------------
module raster_sample_bilinear_raygen #(
  parameter int QUEUE_DEPTH = rsbr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  rsbr_in_if.sink             in_ch,
  rsbr_out_if.source          out_ch,
  input  logic                cfg_we,
  input  rsbr_pkg::cfg_idx_t  cfg_index,
  input  rsbr_pkg::cfg_data_t cfg_data
);
  import rsbr_pkg::*;

  size_t     wide_r, high_r;
  cfg_data_t ll_r, ul_r, lr_r, ur_r;
  size_t     width_eff, height_eff;
  logic      size_wr;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  logic      push, queue_full, pop, head_valid;
  item_t     push_item, head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r <= WIDE_RESET;
      high_r <= HIGH_RESET;
      ll_r   <= '0;
      ul_r   <= '0;
      lr_r   <= '0;
      ur_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PIXELS_WIDE: wide_r <= cfg_data[SIZE_W-1:0];
        REG_PIXELS_HIGH: high_r <= cfg_data[SIZE_W-1:0];
        REG_CORNER_LL:   ll_r   <= cfg_data;
        REG_CORNER_UL:   ul_r   <= cfg_data;
        REG_CORNER_LR:   lr_r   <= cfg_data;
        REG_CORNER_UR:   ur_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // a write to either size reruns the weight setup
  assign size_wr = cfg_we && ((cfg_index == REG_PIXELS_WIDE) ||
                              (cfg_index == REG_PIXELS_HIGH));

  // zero size acts as one, oversize as the largest raster
  assign width_eff  = (wide_r == '0) ? SIZE_ONE : ((wide_r > SIZE_MAX) ? SIZE_MAX : wide_r);
  assign height_eff = (high_r == '0) ? SIZE_ONE : ((high_r > SIZE_MAX) ? SIZE_MAX : high_r);

  rsbr_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  rsbr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .width_i    (width_eff),
    .height_i   (height_eff),
    .size_wr    (size_wr),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  rsbr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  rsbr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .corner_ll  (ll_r),
    .corner_ul  (ul_r),
    .corner_lr  (lr_r),
    .corner_ur  (ur_r),
    .out_ch     (out_ch)
  );

endmodule

>>> rtl/rsbr_div.sv
// ----------------------------------------------------------------------------
// rsbr_div
// restoring divider, one quotient bit per cycle, for the pixel centre weights
// ----------------------------------------------------------------------------
module rsbr_div (
  input  logic               clk,
  input  logic               rst_n,
  input  rsbr_pkg::div_req_t req,
  output rsbr_pkg::div_rsp_t rsp
);
  import rsbr_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  rem_t                 rem_r;
  wt_t                  shq_r;
  size_t                den_r;
  logic [REM_W+1:0]     trial;
  logic                 fits;

  // trial subtract of the divisor from the partial remainder
  assign trial = {1'b0, rem_r, shq_r[WT_W-1]} - {2'b00, den_r};
  assign fits  = ~trial[REM_W+1];

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= DIV_CNT_W'(DIV_STEPS - 1);
    end else if (busy_r) begin
      busy_r <= (cnt_r != '0);
      done_r <= (cnt_r == '0);
      cnt_r  <= cnt_r - DIV_CNT_W'(1);
    end else begin
      done_r <= 1'b0;
    end
  end

  // remainder and shared dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num[DIV_NUM_W-1 -: REM_W];
      shq_r <= req.num[WT_W-1:0];
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= fits ? trial[REM_W-1:0] : {rem_r[REM_W-2:0], shq_r[WT_W-1]};
      shq_r <= {shq_r[WT_W-2:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = shq_r;
  assign rsp.rem  = rem_r;

endmodule

>>> rtl/rsbr_front.sv
// ----------------------------------------------------------------------------
// rsbr_front
// raster scan counters and incremental pixel centre weights; sets up the
// weight bases with the divider after reset and after a size write
// ----------------------------------------------------------------------------
module rsbr_front (
  input  logic               clk,
  input  logic               rst_n,
  rsbr_in_if.sink            in_ch,
  input  rsbr_pkg::size_t    width_i,
  input  rsbr_pkg::size_t    height_i,
  input  logic               size_wr,
  output rsbr_pkg::div_req_t div_req,
  input  rsbr_pkg::div_rsp_t div_rsp,
  output logic               push,
  output rsbr_pkg::item_t    push_item,
  input  logic               queue_full
);
  import rsbr_pkg::*;

  // setup sequencer codes
  localparam logic [2:0] ST_RUN    = 3'd0;
  localparam logic [2:0] ST_BASE_W = 3'd1;
  localparam logic [2:0] ST_BASE_H = 3'd2;
  localparam logic [2:0] ST_CUR_U  = 3'd3;
  localparam logic [2:0] ST_CUR_V  = 3'd4;
  localparam logic [2:0] ST_STEP   = 3'd5;

  logic [2:0] state_r;
  logic       issued_r;
  coord_t     col_r;
  row_t       row_r;
  wpos_t      base_u_r, base_v_r, u_r, v_r;
  wstep_t     step_u_r, step_v_r;

  logic       in_div;
  logic       capture;
  logic       accept;
  logic       wrap;
  row_t       div_idx;
  size_t      div_den;
  coord_t     eff_col;
  row_t       eff_row;
  wpos_t      eff_u, eff_v, nxt_u, nxt_v;
  logic       done_hit;
  logic       last_col;

  // advance a weight position by one pixel
  function automatic wpos_t wt_advance(wpos_t p, wstep_t s, size_t den);
    logic [REM_W:0]  rsum;
    logic            carry;
    logic [STEP_W:0] qsum;
    wpos_t           res;
    rsum  = {1'b0, p.r} + {1'b0, s.r};
    carry = (rsum >= {1'b0, den});
    qsum  = {2'b00, p.q} + {1'b0, s.q} + (STEP_W + 1)'(carry);
    res.q = qsum[WT_W-1:0];
    res.r = carry ? REM_W'(rsum - {1'b0, den}) : rsum[REM_W-1:0];
    return res;
  endfunction

  // per-pixel step from the weight of pixel zero: twice the half step
  function automatic wstep_t step_of(wpos_t b, size_t den);
    logic [REM_W:0] two_r;
    logic           ge;
    wstep_t         res;
    two_r = {b.r, 1'b0};
    ge    = (two_r >= {1'b0, den});
    res.q = {b.q, 1'b0} + STEP_W'(ge);
    res.r = ge ? REM_W'(two_r - {1'b0, den}) : two_r[REM_W-1:0];
    return res;
  endfunction

  // column left beyond a shrunk width moves to the next row
  assign wrap = ({1'b0, col_r} >= width_i);

  // divider job for the current setup step
  assign in_div = (state_r == ST_BASE_W) || (state_r == ST_BASE_H) ||
                  (state_r == ST_CUR_U)  || (state_r == ST_CUR_V);
  assign capture = in_div && issued_r && div_rsp.done;

  always_comb begin
    unique case (state_r)
      ST_BASE_W: begin
        div_idx = '0;
        div_den = width_i;
      end
      ST_BASE_H: begin
        div_idx = '0;
        div_den = height_i;
      end
      ST_CUR_U: begin
        div_idx = wrap ? '0 : ROW_W'(col_r);
        div_den = width_i;
      end
      ST_CUR_V: begin
        div_idx = row_r + ROW_W'(wrap);
        div_den = height_i;
      end
      default: begin
        div_idx = '0;
        div_den = width_i;
      end
    endcase
  end

  assign div_req.start = in_div && !issued_r;
  assign div_req.num   = {div_idx, 1'b1, HALF_SHIFT'(0)};
  assign div_req.den   = div_den;

  // classify the request against the scan position
  assign in_ch.ready = (state_r == ST_RUN) && !queue_full;
  assign accept      = in_ch.valid && in_ch.ready;

  assign eff_col  = (in_ch.restart || wrap) ? '0 : col_r;
  assign eff_row  = in_ch.restart ? '0 : (row_r + ROW_W'(wrap));
  assign eff_u    = in_ch.restart ? base_u_r : u_r;
  assign eff_v    = in_ch.restart ? base_v_r : v_r;
  assign done_hit = (eff_row >= height_i);
  assign last_col = (({1'b0, eff_col} + SIZE_ONE) >= width_i);
  assign nxt_u    = wt_advance(eff_u, step_u_r, width_i);
  assign nxt_v    = wt_advance(eff_v, step_v_r, height_i);

  assign push           = accept;
  assign push_item.sx   = eff_col;
  assign push_item.sy   = eff_row[COORD_BITS-1:0];
  assign push_item.u    = eff_u.q;
  assign push_item.v    = eff_v.q;
  assign push_item.done = done_hit;

  // setup sequencer and scan counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_BASE_W;
      issued_r <= 1'b0;
      col_r    <= '0;
      row_r    <= '0;
    end else if (size_wr) begin
      state_r  <= ST_BASE_W;
      issued_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_RUN: begin
          if (accept) begin
            if (done_hit) begin
              col_r <= '0;
              row_r <= '0;
            end else if (last_col) begin
              col_r <= '0;
              row_r <= eff_row + ROW_W'(1);
            end else begin
              col_r <= eff_col + COORD_BITS'(1);
              row_r <= eff_row;
            end
          end
        end
        ST_BASE_W, ST_BASE_H, ST_CUR_U, ST_CUR_V: begin
          if (!issued_r) begin
            issued_r <= 1'b1;
          end else if (div_rsp.done) begin
            issued_r <= 1'b0;
            state_r  <= state_r + 3'd1;
          end
        end
        ST_STEP: begin
          state_r <= ST_RUN;
        end
        default: begin
          state_r <= ST_BASE_W;
        end
      endcase
    end
  end

  // weight bases, steps and running weights
  always_ff @(posedge clk) begin
    if (capture) begin
      unique case (state_r)
        ST_BASE_W: base_u_r <= {div_rsp.quo, div_rsp.rem};
        ST_BASE_H: base_v_r <= {div_rsp.quo, div_rsp.rem};
        ST_CUR_U:  u_r      <= {div_rsp.quo, div_rsp.rem};
        ST_CUR_V:  v_r      <= {div_rsp.quo, div_rsp.rem};
        default: ;
      endcase
    end
    if (state_r == ST_STEP) begin
      step_u_r <= step_of(base_u_r, width_i);
      step_v_r <= step_of(base_v_r, height_i);
    end
    if (accept) begin
      if (done_hit) begin
        u_r <= base_u_r;
        v_r <= base_v_r;
      end else if (last_col) begin
        u_r <= base_u_r;
        v_r <= nxt_v;
      end else begin
        u_r <= nxt_u;
        v_r <= eff_v;
      end
    end
  end

endmodule

>>> rtl/rsbr_fifo.sv
// ----------------------------------------------------------------------------
// rsbr_fifo
// short request queue between the scan front and the blend back end
// ----------------------------------------------------------------------------
module rsbr_fifo #(
  parameter int DEPTH = rsbr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rsbr_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output rsbr_pkg::item_t head,
  output logic            head_valid
);
  import rsbr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  // pointer and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  assign head       = slot_r[rd_ptr_r];
  assign head_valid = (count_r != '0);
  assign full       = (count_r == CNT_W'(DEPTH));

endmodule

>>> rtl/rsbr_back.sv
// ----------------------------------------------------------------------------
// rsbr_back
// bilinear blend of the four screen corners, one lane per axis, pipelined
// ----------------------------------------------------------------------------
module rsbr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  rsbr_pkg::item_t     head,
  input  logic                head_valid,
  output logic                pop,
  input  rsbr_pkg::cfg_data_t corner_ll,
  input  rsbr_pkg::cfg_data_t corner_ul,
  input  rsbr_pkg::cfg_data_t corner_lr,
  input  rsbr_pkg::cfg_data_t corner_ur,
  rsbr_out_if.source          out_ch
);
  import rsbr_pkg::*;

  localparam int DIFF_W = POINT_W + 1;
  localparam int MUL1_W = 2 * DIFF_W;
  localparam int LR_W   = MUL1_W + 1;
  localparam int MUL2_W = DIFF_W + LR_W;
  localparam int ACC_W  = MUL2_W;
  localparam int RND_BIT = 2 * WT_W - 1;
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) <<< RND_BIT;

  logic   adv;
  logic   s1_v_r, s2_v_r, s3_v_r, out_v_r;
  item_t  s1_item_r, s2_item_r, s3_item_r, out_item_r;
  point_t pt_r [NUM_AXES];

  // whole pipeline moves when the output register frees up
  assign adv = !out_v_r || out_ch.ready;
  assign pop = adv && head_valid;

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= head_valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      out_v_r <= s3_v_r;
    end
  end

  // request fields carried along the stages
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item_r  <= head;
      s2_item_r  <= s1_item_r;
      s3_item_r  <= s2_item_r;
      out_item_r <= s3_item_r;
    end
  end

  // one blend lane per coordinate
  for (genvar k = 0; k < NUM_AXES; k++) begin : g_axis
    point_t                     ll, ul, lr, ur;
    logic signed [DIFF_W-1:0]   d_l, d_r, v_s, u_s;
    logic signed [MUL1_W-1:0]   ml_r, mr_r, left, right;
    logic signed [MUL1_W-1:0]   left2_r, left3_r;
    logic signed [LR_W-1:0]     dlr_r;
    logic signed [MUL2_W-1:0]   prod_r;
    logic signed [ACC_W-1:0]    acc;

    assign ll = corner_ll[k*POINT_W +: POINT_W];
    assign ul = corner_ul[k*POINT_W +: POINT_W];
    assign lr = corner_lr[k*POINT_W +: POINT_W];
    assign ur = corner_ur[k*POINT_W +: POINT_W];

    // vertical differences, weighted by v
    assign d_l = DIFF_W'(ul) - DIFF_W'(ll);
    assign d_r = DIFF_W'(ur) - DIFF_W'(lr);
    assign v_s = $signed({1'b0, head.v});

    always_ff @(posedge clk) begin
      if (adv) begin
        ml_r <= v_s * d_l;
        mr_r <= v_s * d_r;
      end
    end

    // left and right edge points, Q8.24
    assign left  = {{(MUL1_W - POINT_W - WT_W){ll[POINT_W-1]}}, ll, WT_W'(0)} + ml_r;
    assign right = {{(MUL1_W - POINT_W - WT_W){lr[POINT_W-1]}}, lr, WT_W'(0)} + mr_r;

    always_ff @(posedge clk) begin
      if (adv) begin
        left2_r <= left;
        dlr_r   <= LR_W'(right) - LR_W'(left);
      end
    end

    // horizontal difference, weighted by u
    assign u_s = $signed({1'b0, s2_item_r.u});

    always_ff @(posedge clk) begin
      if (adv) begin
        prod_r  <= u_s * dlr_r;
        left3_r <= left2_r;
      end
    end

    // Q8.40 sum, round half up to Q8.8
    assign acc = {{(ACC_W - MUL1_W - WT_W){left3_r[MUL1_W-1]}}, left3_r, WT_W'(0)}
                 + prod_r + RND_HALF;

    always_ff @(posedge clk) begin
      if (adv) begin
        pt_r[k] <= s3_item_r.done ? '0 : acc[2*WT_W +: POINT_W];
      end
    end
  end

  // result register
  assign out_ch.valid    = out_v_r;
  assign out_ch.sample_x = out_item_r.done ? '0 : out_item_r.sx;
  assign out_ch.sample_y = out_item_r.done ? '0 : out_item_r.sy;
  assign out_ch.point_x  = pt_r[0];
  assign out_ch.point_y  = pt_r[1];
  assign out_ch.point_z  = pt_r[2];
  assign out_ch.done_res = out_item_r.done;

endmodule

>>> rtl/rsbr_checker.sv
// ----------------------------------------------------------------------------
// rsbr_checker
// port level checks of the raster sampler, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsbr_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input rsbr_pkg::coord_t sample_x,
  input rsbr_pkg::coord_t sample_y,
  input rsbr_pkg::point_t point_x,
  input rsbr_pkg::point_t point_y,
  input rsbr_pkg::point_t point_z,
  input logic             done_res
);
  import rsbr_pkg::*;

  logic [2*COORD_BITS+3*POINT_W:0] res;
  logic                            stalled;
  logic                            fields_zero;

  // whole result and its stall condition
  assign res         = {sample_x, sample_y, point_x, point_y, point_z, done_res};
  assign stalled     = out_valid && !out_ready;
  assign fields_zero = ({sample_x, sample_y, point_x, point_y, point_z} == '0);

  // a stalled result holds
  `RSBR_ASSERT(a_out_hold, clk, rst_n, stalled |=> out_valid && $stable(res), "stalled result moved")

  // end of scan marker carries no sample
  `RSBR_ASSERT(a_done_zero, clk, rst_n, out_valid && done_res |-> fields_zero, "done not zero")

  // reset empties the result side
  `RSBR_ASSERT_RST(a_rst_out, clk, !rst_n |=> !out_valid, "result valid right after reset")

  // weight setup runs after reset before any request is taken
  `RSBR_ASSERT_RST(a_rst_setup, clk, !rst_n |=> !in_ready, "request taken before weight setup")

endmodule

bind raster_sample_bilinear_raygen rsbr_checker u_rsbr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .sample_x  (out_ch.sample_x),
  .sample_y  (out_ch.sample_y),
  .point_x   (out_ch.point_x),
  .point_y   (out_ch.point_y),
  .point_z   (out_ch.point_z),
  .done_res  (out_ch.done_res)
);

>>> verif/raster_sample_bilinear_raygen_test.sv
// ----------------------------------------------------------------------------
// raster_sample_bilinear_raygen_test
// self-checking bench for the raster scan sampler: a short walk through fixed
// requests and register settings, then random phases of register writes and
// restart requests, each result compared against the sample the plan gives or
// against a cycle-free scan and blend predictor
// ----------------------------------------------------------------------------
module raster_sample_bilinear_raygen_test;
  import rsbr_pkg::*;

  localparam int       CYCLE_LIMIT   = 600000;
  localparam int       SETTLE_CYCLES = 12;
  localparam int       RANDOM_ITEMS  = 2000;
  localparam int       LONG_PHASE    = 4;
  localparam int       LONG_WIDTH    = 1021;
  localparam longint   Q16_ONE       = 65536;
  localparam cfg_idx_t REG_UNUSED    = CFG_IDX_W'(7);

  localparam int CORNER_LL = 0;
  localparam int CORNER_UL = 1;
  localparam int CORNER_LR = 2;
  localparam int CORNER_UR = 3;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    point_t px;
    point_t py;
    point_t pz;
    logic   done;
  } sample_t;

  typedef enum logic {ROW_WRITE, ROW_REQUEST} row_kind_e;

  typedef struct {
    row_kind_e kind;
    cfg_idx_t  idx;
    cfg_data_t data;
    logic      restart;
    logic      typed;
    sample_t   want;
  } plan_row_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} stall_e;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  rsbr_in_if  req_ch ();
  rsbr_out_if smp_ch ();

  raster_sample_bilinear_raygen dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (smp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor copy of the registers and the scan position
  logic [SIZE_W-1:0] wide_reg;
  logic [SIZE_W-1:0] high_reg;
  cfg_data_t         eye_reg;
  cfg_data_t         corner_reg [4];
  int                scan_col;
  int                scan_row;

  sample_t   pending_samples [$];
  plan_row_t plan [$];
  int        fault_count = 0;
  int        cycle_count = 0;
  bit        unsettled   = 1'b0;

  // clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("raster_sample_bilinear_raygen_test: errors");
      $finish;
    end
  end

  // size as the scan sees it: zero acts as one, oversize clamps
  function automatic int eff_size(logic [SIZE_W-1:0] s);
    if (s == '0) return 1;
    if (s > SIZE_MAX) return int'(SIZE_MAX);
    return int'(s);
  endfunction

  // q0.16 weight of a pixel centre
  function automatic longint centre_weight(int idx, int size);
    return (longint'(2 * idx + 1) << 16) / (2 * longint'(size));
  endfunction

  function automatic longint corner_coord(int corner, int axis);
    point_t f;
    f = corner_reg[corner][16*axis +: 16];
    return longint'(f);
  endfunction

  // exact bilinear blend, rounded half up to q8.8
  function automatic point_t blend_axis(int axis, longint u, longint v);
    longint iu, iv, left, right, acc;
    iu    = Q16_ONE - u;
    iv    = Q16_ONE - v;
    left  = iv * corner_coord(CORNER_LL, axis) + v * corner_coord(CORNER_UL, axis);
    right = iv * corner_coord(CORNER_LR, axis) + v * corner_coord(CORNER_UR, axis);
    acc   = iu * left + u * right;
    acc   = (acc + (longint'(1) << 31)) >>> 32;
    return point_t'(acc[15:0]);
  endfunction

  // advance the scan by one request and give its sample
  function automatic sample_t predict_sample(logic restart);
    sample_t r;
    int      w, h;
    longint  u, v;
    r = '0;
    w = eff_size(wide_reg);
    h = eff_size(high_reg);
    if (restart) begin
      scan_col = 0;
      scan_row = 0;
    end
    // column left beyond a shrunk width wraps first
    if (scan_col >= w) begin
      scan_col = 0;
      scan_row = (scan_row + 1) % 8192;
    end
    // past the last row: done, scan starts over
    if (scan_row >= h) begin
      scan_col = 0;
      scan_row = 0;
      r.done   = 1'b1;
      return r;
    end
    u    = centre_weight(scan_col, w);
    v    = centre_weight(scan_row, h);
    r.sx = coord_t'(scan_col);
    r.sy = coord_t'(scan_row);
    r.px = blend_axis(0, u, v);
    r.py = blend_axis(1, u, v);
    r.pz = blend_axis(2, u, v);
    if (scan_col + 1 >= w) begin
      scan_col = 0;
      scan_row = (scan_row + 1) % 8192;
    end else begin
      scan_col = (scan_col + 1) % 4096;
    end
    return r;
  endfunction

  function automatic void store_reg(cfg_idx_t idx, cfg_data_t data);
    case (idx)
      REG_PIXELS_WIDE: begin
        wide_reg = data[SIZE_W-1:0];
      end
      REG_PIXELS_HIGH: begin
        high_reg = data[SIZE_W-1:0];
      end
      REG_EYE_POSITION: begin
        eye_reg = data;
      end
      REG_CORNER_LL, REG_CORNER_UL, REG_CORNER_LR, REG_CORNER_UR: begin
        corner_reg[int'(idx - REG_CORNER_LL)] = data;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic cfg_data_t pack_point(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    return {z, y, x};
  endfunction

  function automatic sample_t make_sample(int x, int y, logic [15:0] px, logic [15:0] py,
                                          logic [15:0] pz, logic done);
    sample_t r;
    r.sx   = coord_t'(x);
    r.sy   = coord_t'(y);
    r.px   = px;
    r.py   = py;
    r.pz   = pz;
    r.done = done;
    return r;
  endfunction

  // directed plan rows
  function automatic void add_write(cfg_idx_t idx, cfg_data_t data);
    plan_row_t row;
    row.kind    = ROW_WRITE;
    row.idx     = idx;
    row.data    = data;
    row.restart = 1'b0;
    row.typed   = 1'b0;
    row.want    = '0;
    plan.push_back(row);
  endfunction

  function automatic void add_request(logic restart, logic typed, sample_t want);
    plan_row_t row;
    row.kind    = ROW_REQUEST;
    row.idx     = REG_PIXELS_WIDE;
    row.data    = '0;
    row.restart = restart;
    row.typed   = typed;
    row.want    = want;
    plan.push_back(row);
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch @%0d: %s", cycle_count, what);
    fault_count++;
  endtask

  task automatic compare_sample(sample_t got, sample_t want);
    string at;
    at = $sformatf("(want x=%0d y=%0d done=%0b)", want.sx, want.sy, want.done);
    if (got.done !== want.done)
      report_mismatch($sformatf("done_res %0b %s", got.done, at));
    if (got.sx !== want.sx)
      report_mismatch($sformatf("sample_x %0d %s", got.sx, at));
    if (got.sy !== want.sy)
      report_mismatch($sformatf("sample_y %0d %s", got.sy, at));
    if (got.px !== want.px)
      report_mismatch($sformatf("point_x %0d want %0d %s", got.px, want.px, at));
    if (got.py !== want.py)
      report_mismatch($sformatf("point_y %0d want %0d %s", got.py, want.py, at));
    if (got.pz !== want.pz)
      report_mismatch($sformatf("point_z %0d want %0d %s", got.pz, want.pz, at));
  endtask

  // result monitor
  always @(posedge clk) begin
    sample_t got;
    sample_t want;
    if (rst_n && smp_ch.valid && smp_ch.ready) begin
      got = {smp_ch.sample_x, smp_ch.sample_y, smp_ch.point_x, smp_ch.point_y,
             smp_ch.point_z, smp_ch.done_res};
      if (pending_samples.size() == 0) begin
        report_mismatch($sformatf("sample with nothing pending: x=%0d y=%0d done=%0b",
                                  got.sx, got.sy, got.done));
      end else begin
        want = pending_samples.pop_front();
        compare_sample(got, want);
      end
    end
  end

  // result stalls: none, random, periodic or long toggling, a new pattern drawn when a run ends
  initial begin
    stall_e mode;
    int     left;
    int     tick;
    smp_ch.ready = 1'b0;
    mode = STALL_NONE;
    left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = stall_e'($urandom_range(0, 3));
        left = $urandom_range(50, 250);
      end
      left--;
      tick++;
      case (mode)
        STALL_NONE: begin
          smp_ch.ready = 1'b1;
        end
        STALL_RANDOM: begin
          smp_ch.ready = ($urandom_range(0, 3) != 0);
        end
        STALL_PERIODIC: begin
          smp_ch.ready = ((tick % 9) < 4);
        end
        default: begin
          if ($urandom_range(0, 11) == 0) smp_ch.ready = !smp_ch.ready;
        end
      endcase
    end
  end

  // wait until every pending sample is back and the block is quiet
  task automatic drain_results();
    req_ch.valid = 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // register write, only with the block idle
  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    if (unsettled) begin
      drain_results();
      unsettled = 1'b0;
    end
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    store_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
    @(negedge clk);
  endtask

  // one request; called at a falling edge, returns at a falling edge
  task automatic send_request(logic restart, logic typed, sample_t want);
    sample_t predicted;
    req_ch.valid   = 1'b1;
    req_ch.restart = restart;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    predicted = predict_sample(restart);
    pending_samples.push_back(typed ? want : predicted);
    unsettled = 1'b1;
    @(negedge clk);
  endtask

  task automatic pause_requests(int n);
    if (n > 0) begin
      req_ch.valid = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return SIZE_W'($urandom_range(1, 6));
    if (sel < 85) return SIZE_W'($urandom_range(7, 40));
    if (sel < 90) return '0;
    if (sel < 95) return SIZE_MAX;
    return SIZE_W'($urandom_range(4097, 8191));
  endfunction

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 15))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cfg_data_t pick_point();
    return pack_point(pick_coord(), pick_coord(), pick_coord());
  endfunction

  function automatic cfg_data_t pick_junk();
    return cfg_data_t'({$urandom, $urandom});
  endfunction

  // new register settings for a random phase
  task automatic randomize_registers();
    cfg_data_t upper;
    upper = ($urandom_range(0, 1) == 0) ? '0 : pick_junk();
    if ($urandom_range(0, 3) != 0)
      write_reg(REG_PIXELS_WIDE, {upper[CFG_DATA_W-1:SIZE_W], pick_size()});
    if ($urandom_range(0, 3) != 0)
      write_reg(REG_PIXELS_HIGH, {upper[CFG_DATA_W-1:SIZE_W], pick_size()});
    if ($urandom_range(0, 1) == 0) write_reg(REG_EYE_POSITION, pick_junk());
    if ($urandom_range(0, 3) != 0) write_reg(REG_CORNER_LL, pick_point());
    if ($urandom_range(0, 3) != 0) write_reg(REG_CORNER_UL, pick_point());
    if ($urandom_range(0, 3) != 0) write_reg(REG_CORNER_LR, pick_point());
    if ($urandom_range(0, 3) != 0) write_reg(REG_CORNER_UR, pick_point());
    if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, pick_junk());
  endtask

  // main sequence
  initial begin
    int   random_sent;
    int   phase;
    int   count;
    int   frame;
    int   burst_left;
    bit   gapless;
    logic restart;

    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_PIXELS_WIDE;
    cfg_data       = '0;
    req_ch.valid   = 1'b0;
    req_ch.restart = 1'b0;

    wide_reg = WIDE_RESET;
    high_reg = HIGH_RESET;
    eye_reg  = '0;
    foreach (corner_reg[i]) corner_reg[i] = '0;
    scan_col = 0;
    scan_row = 0;

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // reset values: 640x480 scan over a quad of zeros
    add_request(1'b0, 1'b1, make_sample(0, 0, 16'h0, 16'h0, 16'h0, 1'b0));
    add_request(1'b0, 1'b1, make_sample(1, 0, 16'h0, 16'h0, 16'h0, 1'b0));
    add_request(1'b1, 1'b1, make_sample(0, 0, 16'h0, 16'h0, 16'h0, 1'b0));

    // zero width through masked upper bits, one row, flat extreme quad
    add_write(REG_PIXELS_WIDE, {35'h7_FFFF_FFFF, 13'd0});
    add_write(REG_PIXELS_HIGH, cfg_data_t'(1));
    add_write(REG_UNUSED, '1);
    add_write(REG_EYE_POSITION, pack_point(16'h7FFF, 16'h8000, 16'h1234));
    add_write(REG_CORNER_LL, pack_point(16'h7FFF, 16'h8000, 16'h0000));
    add_write(REG_CORNER_UL, pack_point(16'h7FFF, 16'h8000, 16'h0000));
    add_write(REG_CORNER_LR, pack_point(16'h7FFF, 16'h8000, 16'h0000));
    add_write(REG_CORNER_UR, pack_point(16'h7FFF, 16'h8000, 16'h0000));
    add_request(1'b1, 1'b1, make_sample(0, 0, 16'h7FFF, 16'h8000, 16'h0, 1'b0));
    add_request(1'b0, 1'b1, make_sample(0, 0, 16'h0, 16'h0, 16'h0, 1'b1));
    add_request(1'b0, 1'b1, make_sample(0, 0, 16'h7FFF, 16'h8000, 16'h0, 1'b0));

    // oversize width, mixed extreme corners
    add_write(REG_CORNER_LL, pack_point(16'h8000, 16'h7FFF, 16'h8000));
    add_write(REG_CORNER_UL, pack_point(16'h7FFF, 16'h8000, 16'h7FFF));
    add_write(REG_CORNER_LR, pack_point(16'h7FFF, 16'h7FFF, 16'h8000));
    add_write(REG_CORNER_UR, pack_point(16'h8000, 16'h8000, 16'h0001));
    add_write(REG_PIXELS_WIDE, cfg_data_t'(8191));
    add_write(REG_PIXELS_HIGH, cfg_data_t'(2));
    add_request(1'b1, 1'b0, '0);
    add_request(1'b0, 1'b0, '0);
    add_request(1'b0, 1'b0, '0);

    // width shrunk below the current column, then past the last row
    add_write(REG_PIXELS_WIDE, cfg_data_t'(2));
    add_request(1'b0, 1'b0, '0);
    add_request(1'b0, 1'b0, '0);
    add_request(1'b0, 1'b1, make_sample(0, 0, 16'h0, 16'h0, 16'h0, 1'b1));

    // height shrunk below the current row
    add_write(REG_PIXELS_HIGH, cfg_data_t'(4));
    add_request(1'b0, 1'b0, '0);
    add_request(1'b0, 1'b0, '0);
    add_request(1'b0, 1'b0, '0);
    add_write(REG_PIXELS_HIGH, cfg_data_t'(1));
    add_request(1'b0, 1'b1, make_sample(0, 0, 16'h0, 16'h0, 16'h0, 1'b1));
    add_request(1'b0, 1'b0, '0);

    // largest exact size, then a small grid with a restart mid-scan
    add_write(REG_PIXELS_WIDE, cfg_data_t'(SIZE_MAX));
    add_write(REG_PIXELS_HIGH, cfg_data_t'(SIZE_MAX));
    add_write(REG_CORNER_LL, pack_point(16'h0100, 16'hFF00, 16'h0080));
    add_request(1'b1, 1'b0, '0);
    add_request(1'b0, 1'b0, '0);
    add_write(REG_PIXELS_WIDE, cfg_data_t'(3));
    add_write(REG_PIXELS_HIGH, cfg_data_t'(3));
    add_request(1'b1, 1'b0, '0);
    add_request(1'b0, 1'b0, '0);
    add_request(1'b1, 1'b0, '0);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) write_reg(plan[i].idx, plan[i].data);
      else send_request(plan[i].restart, plan[i].typed, plan[i].want);
    end

    // random phases
    random_sent = 0;
    phase       = 0;
    burst_left  = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (phase == LONG_PHASE) begin
        // one full row at a wide odd width reaches the last column
        write_reg(REG_PIXELS_WIDE, cfg_data_t'(LONG_WIDTH));
        write_reg(REG_PIXELS_HIGH, cfg_data_t'(SIZE_ONE));
        count = LONG_WIDTH + 2;
      end else begin
        if ($urandom_range(0, 6) != 0) randomize_registers();
        frame = eff_size(wide_reg) * eff_size(high_reg) + 1;
        if (frame > 80) frame = 80;
        count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8)
                                             : $urandom_range(1, 2 * frame);
      end
      gapless = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < count; i++) begin
        if (burst_left == 0) begin
          pause_requests(gapless ? 0 : $urandom_range(0, 6));
          burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        if (phase == LONG_PHASE) restart = (i == 0);
        else if (i == 0) restart = ($urandom_range(0, 2) == 0);
        else restart = ($urandom_range(0, 39) == 0);
        send_request(restart, 1'b0, '0);
        random_sent++;
      end
      phase++;
    end

    // wind down
    req_ch.valid = 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("raster_sample_bilinear_raygen_test: clean");
    end else begin
      $display("raster_sample_bilinear_raygen_test: errors");
    end
    $finish;
  end

endmodule
